// ===== src/bmm_pkg.sv =====
package bmm_pkg;

    typedef enum logic [1:0] {
        OP_IO_WRITE  = 2'd0,
        OP_MEM_READ  = 2'd1,
        OP_MEM_WRITE = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    localparam logic [1:0] SRC_RAM       = 2'd0;
    localparam logic [1:0] SRC_LOWER_ROM = 2'd1;
    localparam logic [1:0] SRC_UPPER_ROM = 2'd2;

    localparam logic [3:0] RAM_SIZE_RESET = 4'd2;

    // RAM config bits 5..3 hold the encoded expansion bank, 2..0 the table row
    typedef struct packed {
        logic [5:0] ram_ctl;
        logic [2:0] exp_bank;
    } t_bank_cfg;

    typedef struct packed {
        logic       lower_rom_off;
        logic       upper_rom_off;
        t_bank_cfg  bank;
        logic [7:0] upper_rom_sel;
    } t_map_state;

    typedef struct packed {
        logic [1:0]  source;
        logic [5:0]  ram_block;
        logic [13:0] offset;
        logic [7:0]  rom_number;
    } t_map_result;

    function automatic t_bank_cfg normalize_bank(input logic [3:0] size_64k,
                                                 input t_bank_cfg cur);
        t_bank_cfg  res;
        logic [3:0] limit;
        logic [2:0] want;
        res   = cur;
        limit = size_64k - 4'd2;
        want  = cur.exp_bank;
        if (size_64k <= 4'd1) begin
            res.ram_ctl  = '0;
            res.exp_bank = '0;
        end else begin
            if ({1'b0, cur.ram_ctl[5:3]} <= limit) begin
                want = cur.ram_ctl[5:3];
            end
            if ({1'b0, want} > limit) begin
                want = '0;
            end
            res.exp_bank = want;
        end
        return res;
    endfunction

    // 16K block for each slot; values 4..7 select inside the expansion bank
    function automatic logic [2:0] bank_lookup(input logic [2:0] cfg,
                                               input logic [1:0] slot);
        logic [11:0] row;
        case (cfg)
            3'd0:    row = {3'd3, 3'd2, 3'd1, 3'd0};
            3'd1:    row = {3'd7, 3'd2, 3'd1, 3'd0};
            3'd2:    row = {3'd7, 3'd6, 3'd5, 3'd4};
            3'd3:    row = {3'd7, 3'd2, 3'd3, 3'd0};
            3'd4:    row = {3'd3, 3'd2, 3'd4, 3'd0};
            3'd5:    row = {3'd3, 3'd2, 3'd5, 3'd0};
            3'd6:    row = {3'd3, 3'd2, 3'd6, 3'd0};
            default: row = {3'd3, 3'd2, 3'd7, 3'd0};
        endcase
        return row[slot * 3 +: 3];
    endfunction

endpackage

// ===== src/bmm_state.sv =====
module bmm_state (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [3:0]            i_cfg_ram_size_64k,
    input  logic                  i_io_we,
    input  logic [7:0]            i_port_high,
    input  logic [7:0]            i_data_value,
    output bmm_pkg::t_map_state   o_state,
    output logic                  o_irq_clear
);
    import bmm_pkg::*;

    logic [3:0] r_ram_size;
    logic [3:0] n_ram_size;
    t_map_state r_state;
    t_map_state n_state;
    logic       rom_hit;
    logic       ram_hit;
    logic       upper_hit;
    t_bank_cfg  bank_tmp;

    assign rom_hit   = (i_port_high[7:6] == 2'b01) && (i_data_value[7:6] == 2'b10);
    assign ram_hit   = !i_port_high[7] && (i_data_value[7:6] == 2'b11);
    assign upper_hit = !i_port_high[5];

    always_comb begin
        n_state    = r_state;
        n_ram_size = r_ram_size;
        bank_tmp   = r_state.bank;
        if (i_cfg_we) begin
            n_ram_size   = i_cfg_ram_size_64k;
            n_state.bank = normalize_bank(i_cfg_ram_size_64k, r_state.bank);
        end else if (i_io_we) begin
            if (rom_hit) begin
                n_state.lower_rom_off = i_data_value[2];
                n_state.upper_rom_off = i_data_value[3];
                bank_tmp = normalize_bank(r_ram_size, bank_tmp);
            end
            if (ram_hit) begin
                bank_tmp.ram_ctl  = i_data_value[5:0];
                bank_tmp.exp_bank = i_data_value[5:3];
                bank_tmp = normalize_bank(r_ram_size, bank_tmp);
            end
            n_state.bank = bank_tmp;
            if (upper_hit) begin
                n_state.upper_rom_sel = i_data_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_size <= RAM_SIZE_RESET;
            r_state    <= '0;
        end else begin
            r_ram_size <= n_ram_size;
            r_state    <= n_state;
        end
    end

    assign o_state     = r_state;
    assign o_irq_clear = rom_hit && i_data_value[4];

endmodule

// ===== src/bmm_map.sv =====
module bmm_map (
    input  logic [1:0]            i_op,
    input  logic [15:0]           i_address,
    input  bmm_pkg::t_map_state   i_state,
    output bmm_pkg::t_map_result  o_result
);
    import bmm_pkg::*;

    t_op        op;
    logic [1:0] slot;
    logic [2:0] entry;
    logic [3:0] bank_base;

    assign op        = t_op'(i_op);
    assign slot      = i_address[15:14];
    assign entry     = bank_lookup(i_state.bank.ram_ctl[2:0], slot);
    assign bank_base = {1'b0, i_state.bank.exp_bank} + 4'd1;

    always_comb begin
        o_result = '0;
        case (op)
            OP_MEM_READ, OP_MEM_WRITE: begin
                o_result.offset = i_address[13:0];
                if (op == OP_MEM_READ && slot == 2'd0 && !i_state.lower_rom_off) begin
                    o_result.source = SRC_LOWER_ROM;
                end else if (op == OP_MEM_READ && slot == 2'd3
                             && !i_state.upper_rom_off) begin
                    o_result.source     = SRC_UPPER_ROM;
                    o_result.rom_number = i_state.upper_rom_sel;
                end else if (!entry[2]) begin
                    o_result.source    = SRC_RAM;
                    o_result.ram_block = {4'd0, entry[1:0]};
                end else begin
                    o_result.source    = SRC_RAM;
                    o_result.ram_block = {bank_base, entry[1:0]};
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

// ===== src/banked_memory_mapper.sv =====
// Two register stages; one item per cycle unless the output stalls. The input
// register feeds the translation logic and the banking state, which update
// together into the output register; an item leaves the input register when
// the output register can take it. Configuration writes are always ready.
// Reset (synchronous, active low): pipeline empty, RAM size 2, ROMs enabled,
// RAM config, expansion bank and upper ROM number zero.
module banked_memory_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_port_high,
    input  logic [7:0]  i_data_value,
    input  logic [15:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_source,
    output logic [5:0]  o_ram_block,
    output logic [13:0] o_offset,
    output logic [7:0]  o_rom_number,
    output logic        o_irq_clear,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_ram_size_64k
);
    import bmm_pkg::*;

    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [7:0]  r_s1_port_high;
    logic [7:0]  r_s1_data_value;
    logic [15:0] r_s1_address;
    logic        r_out_valid;
    t_map_result r_out;
    logic        r_out_irq;
    logic        s1_adv;
    logic        in_take;
    logic        io_we;
    logic        irq_hit;
    t_map_state  map_state;
    t_map_result map_res;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_take    = i_in_valid && !o_in_stall;
    assign io_we      = r_s1_valid && s1_adv && (t_op'(r_s1_op) == OP_IO_WRITE);
    assign o_cfg_ready = 1'b1;

    bmm_state u_state (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_ram_size_64k (i_cfg_ram_size_64k),
        .i_io_we            (io_we),
        .i_port_high        (r_s1_port_high),
        .i_data_value       (r_s1_data_value),
        .o_state            (map_state),
        .o_irq_clear        (irq_hit)
    );

    bmm_map u_map (
        .i_op      (r_s1_op),
        .i_address (r_s1_address),
        .i_state   (map_state),
        .o_result  (map_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op         <= i_op;
            r_s1_port_high  <= i_port_high;
            r_s1_data_value <= i_data_value;
            r_s1_address    <= i_address;
        end
        if (s1_adv && r_s1_valid) begin
            r_out     <= map_res;
            r_out_irq <= io_we && irq_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_source     = r_out.source;
    assign o_ram_block  = r_out.ram_block;
    assign o_offset     = r_out.offset;
    assign o_rom_number = r_out.rom_number;
    assign o_irq_clear  = r_out_irq;

endmodule
